// File: src/cbs_pkg.sv
// Shared types, field widths and command codes of the credit-based shaper.
package cbs_pkg;

  localparam int FRAME_BITS_WIDTH = 14;
  localparam int CREDIT_WIDTH_DEF = 32;
  localparam int CFG_WIDTH = 16;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_GATE_CHANGE = 3'd1;
  localparam logic [2:0] OP_FRAME_ENQUEUED = 3'd2;
  localparam logic [2:0] OP_SEND_FRAME = 3'd3;
  localparam logic [2:0] OP_TX_DONE = 3'd4;

  localparam logic REG_IDLE_CREDIT = 1'b0;
  localparam logic REG_SEND_FRACTION = 1'b1;

  localparam logic [CFG_WIDTH-1:0] IDLE_CREDIT_RESET = 16'd256;
  localparam logic [CFG_WIDTH-1:0] SEND_FRACTION_RESET = 16'd32768;

  typedef struct packed {
    logic [2:0]                  op;
    logic                        gate_open;
    logic                        frame_ready;
    logic [FRAME_BITS_WIDTH-1:0] frame_bits;
  } req_t;

  typedef struct packed {
    logic signed [31:0] credit_now;
    logic               eligible;
    logic               notify;
    logic [1:0]         shaper_mode;
  } res_t;

endpackage

// File: src/credit_based_shaper.sv
// Credit-based shaper for one traffic class: request register, credit update and result register.
//
// Requests arrive on req_valid/req_ready with one event each: tick, gate change,
// frame enqueued, send frame or transmission done. Every request produces exactly
// one result on res_valid/res_ready carrying the credit, eligibility, the notify
// pulse and the shaper mode after that event.
// A request is registered in the cycle it is accepted; the send product of frame
// bits and send fraction is formed there. The credit and mode update in the next
// stage, where the result register is loaded together with them.
// One request is accepted in every cycle while results are taken; the rate is set
// by the combinational credit add or subtract feeding back into the credit register.
// When the receiver stalls, the result register holds its result; the request
// register takes one more request only if it was empty, and req_ready drops.
// The user must write configuration through cfg_we, cfg_index and cfg_data only
// while no request is in flight; the block does not enforce it. Reset zeroes the
// credit, sets idle mode and default registers and empties both stages.
module credit_based_shaper #(
  parameter int CREDIT_WIDTH = cbs_pkg::CREDIT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  cbs_pkg::req_t                  req,
  output logic                           res_valid,
  input  logic                           res_ready,
  output cbs_pkg::res_t                  res,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [cbs_pkg::CFG_WIDTH-1:0]  cfg_data
);
  import cbs_pkg::*;

  localparam int SPEND_WIDTH = FRAME_BITS_WIDTH + CFG_WIDTH - 8;
  localparam int PROD_WIDTH = FRAME_BITS_WIDTH + CFG_WIDTH;
  localparam logic signed [CREDIT_WIDTH-1:0] CreditFloor = CREDIT_WIDTH'(-256);
  localparam logic signed [CREDIT_WIDTH-1:0] CreditMax = {1'b0, {(CREDIT_WIDTH-1){1'b1}}};
  localparam logic signed [CREDIT_WIDTH-1:0] CreditMin = {1'b1, {(CREDIT_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_SPEND = 2'd1,
    MODE_EARN  = 2'd2
  } mode_t;

  logic [CFG_WIDTH-1:0] idle_credit;
  logic [CFG_WIDTH-1:0] send_fraction;

  logic                   s1_valid;
  req_t                   s1;
  logic [SPEND_WIDTH-1:0] spend;
  logic [PROD_WIDTH-1:0]  product;

  logic signed [CREDIT_WIDTH-1:0] credit;
  logic signed [CREDIT_WIDTH-1:0] credit_next;
  mode_t                          mode;
  mode_t                          mode_next;
  logic                           notify_next;

  logic                           s2_adv;
  logic signed [CREDIT_WIDTH:0]   sum_add;
  logic signed [CREDIT_WIDTH:0]   sum_sub;
  logic signed [CREDIT_WIDTH-1:0] credit_add;
  logic signed [CREDIT_WIDTH-1:0] credit_sub;
  logic                           ok_now;
  logic [63:0]                    credit_ext;

  assign s2_adv = !res_valid || res_ready;
  assign req_ready = !s1_valid || s2_adv;
  assign product = FRAME_BITS_WIDTH'(req.frame_bits) * send_fraction;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_credit <= IDLE_CREDIT_RESET;
      send_fraction <= SEND_FRACTION_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IDLE_CREDIT: idle_credit <= cfg_data;
        REG_SEND_FRACTION: send_fraction <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
    if (req_ready && req_valid) begin
      s1 <= req;
      spend <= product[PROD_WIDTH-1:8];
    end
  end

  always_comb begin
    sum_add = {credit[CREDIT_WIDTH-1], credit} + (CREDIT_WIDTH+1)'(idle_credit);
    sum_sub = {credit[CREDIT_WIDTH-1], credit} - (CREDIT_WIDTH+1)'(spend);
    credit_add = (sum_add[CREDIT_WIDTH] != sum_add[CREDIT_WIDTH-1]) ? CreditMax
                                                                   : sum_add[CREDIT_WIDTH-1:0];
    credit_sub = (sum_sub[CREDIT_WIDTH] != sum_sub[CREDIT_WIDTH-1]) ? CreditMin
                                                                   : sum_sub[CREDIT_WIDTH-1:0];
    ok_now = credit > CreditFloor;
    credit_next = credit;
    mode_next = mode;
    notify_next = 1'b0;
    case (s1.op)
      OP_TICK: begin
        if (mode == MODE_EARN) begin
          credit_next = credit_add;
          notify_next = !ok_now && (credit_add > CreditFloor) && s1.frame_ready;
        end
      end
      OP_GATE_CHANGE: begin
        if (s1.gate_open) begin
          if (mode == MODE_IDLE && s1.frame_ready) mode_next = MODE_EARN;
        end else if (mode == MODE_EARN) begin
          mode_next = MODE_IDLE;
        end
      end
      OP_FRAME_ENQUEUED: begin
        if (mode == MODE_IDLE && s1.gate_open) mode_next = MODE_EARN;
        notify_next = ok_now && s1.frame_ready;
      end
      OP_SEND_FRAME: begin
        credit_next = credit_sub;
        mode_next = MODE_SPEND;
      end
      OP_TX_DONE: begin
        if (mode == MODE_SPEND) begin
          if (!s1.frame_ready && ok_now) begin
            credit_next = '0;
            mode_next = MODE_IDLE;
          end else if (s1.frame_ready && s1.gate_open) begin
            mode_next = MODE_EARN;
          end else begin
            mode_next = MODE_IDLE;
          end
        end
      end
      default: ;
    endcase
    credit_ext = {{(64-CREDIT_WIDTH){credit_next[CREDIT_WIDTH-1]}}, credit_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      credit <= '0;
      mode <= MODE_IDLE;
    end else if (s2_adv) begin
      res_valid <= s1_valid;
      if (s1_valid) begin
        credit <= credit_next;
        mode <= mode_next;
      end
    end
    if (s2_adv && s1_valid) begin
      res.credit_now <= credit_ext[31:0];
      res.eligible <= credit_next > CreditFloor;
      res.notify <= notify_next;
      res.shaper_mode <= mode_next;
    end
  end

  a_notify_eligible: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.notify) |-> res.eligible)
    else $error("notify raised on an ineligible result");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> s1_valid)
    else $error("accepted request lost from request register");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_adv) |=> (s1_valid && $stable(s1) && $stable(spend)))
    else $error("request register changed while stalled");

  a_spend_mode: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_adv && s1.op == OP_SEND_FRAME) |=> (mode == MODE_SPEND))
    else $error("send did not enter spending mode");

endmodule
